>>> rtl/core/dfs_pkg.sv
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types and constants of the FR-FCFS DRAM request scheduler.
// ----------------------------------------------------------------------------
package dfs_pkg;

    // default sizes
    localparam int PENDING_DEPTH_DEF = 16;
    localparam int ONGOING_DEPTH_DEF = 8;
    localparam int TAG_BITS_DEF      = 32;

    // fixed field widths
    localparam int FIELD_TAG_W = 32;
    localparam int CYCLE_W     = 32;
    localparam int CMD_W       = 5;
    localparam int BANK_BUSY_W = 10;
    localparam int DATA_BUS_W  = 8;
    localparam int CFG_W       = 32;
    localparam int CFG_AW      = 2;
    localparam int BANK_W      = 3;
    localparam int COUNT_W     = 5;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 72;

    // window arithmetic: cycle plus at most three bank holds and a transfer
    localparam int WIN_W = CYCLE_W + 2;

    // tag bits that select the bank
    localparam int BANK_LSB = 5;

    // reset values of the timing registers
    localparam logic [CMD_W-1:0]       CMD_BUS_RST   = 5'd4;
    localparam logic [BANK_BUSY_W-1:0] BANK_BUSY_RST = 10'd100;
    localparam logic [DATA_BUS_W-1:0]  DATA_BUS_RST  = 8'd50;
    localparam logic [CFG_W-1:0]       ROW_MASK_RST  = 32'hFFFF_FF00;

    // register indexes
    typedef enum logic [CFG_AW-1:0] {
        REG_CMD_BUS   = 2'd0,
        REG_BANK_BUSY = 2'd1,
        REG_DATA_BUS  = 2'd2,
        REG_ROW_MASK  = 2'd3
    } reg_idx_t;

    // input opcodes
    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    // row buffer status
    typedef enum logic [1:0] {
        KIND_HIT      = 2'd0,
        KIND_MISS     = 2'd1,
        KIND_CONFLICT = 2'd2
    } kind_t;

    // all windows of one scheduled request
    typedef struct packed {
        logic [2:0]            used;
        logic [2:0][WIN_W-1:0] cs;
        logic [2:0][WIN_W-1:0] ce;
        logic [WIN_W-1:0]      bank_s;
        logic [WIN_W-1:0]      bank_e;
        logic [WIN_W-1:0]      data_s;
        logic [WIN_W-1:0]      data_e;
    } win_t;

endpackage

>>> rtl/core/dfs_clash.sv
// ----------------------------------------------------------------------------
// dfs_clash
// Checks a candidate's windows against every ongoing request in parallel.
// ----------------------------------------------------------------------------
module dfs_clash #(
    parameter int ONGOING_DEPTH = dfs_pkg::ONGOING_DEPTH_DEF
) (
    input  dfs_pkg::win_t                                cand,
    input  logic [dfs_pkg::BANK_W-1:0]                   cand_bank,
    input  logic [ONGOING_DEPTH-1:0]                     ong_valid,
    input  dfs_pkg::win_t [ONGOING_DEPTH-1:0]            ong_win,
    input  logic [ONGOING_DEPTH-1:0][dfs_pkg::BANK_W-1:0] ong_bank,
    output logic                                         clash
);
    import dfs_pkg::*;

    logic [ONGOING_DEPTH-1:0] hit;

    // inclusive overlap of two windows
    function automatic logic ovl(input logic [WIN_W-1:0] as, input logic [WIN_W-1:0] ae,
                                 input logic [WIN_W-1:0] bs, input logic [WIN_W-1:0] be);
        ovl = (as <= be) && (bs <= ae);
    endfunction

    // per ongoing entry: command bus, data bus and same-bank checks
    always_comb
    begin
        for (int o = 0; o < ONGOING_DEPTH; o++)
        begin
            hit[o] = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    if (ong_win[o].used[i] && cand.used[j] &&
                        ovl(ong_win[o].cs[i], ong_win[o].ce[i], cand.cs[j], cand.ce[j]))
                    begin
                        hit[o] = 1'b1;
                    end
                end
            end
            if (ovl(ong_win[o].data_s, ong_win[o].data_e, cand.data_s, cand.data_e))
            begin
                hit[o] = 1'b1;
            end
            if ((ong_bank[o] == cand_bank) &&
                ovl(ong_win[o].bank_s, ong_win[o].bank_e, cand.bank_s, cand.bank_e))
            begin
                hit[o] = 1'b1;
            end
            hit[o] = hit[o] && ong_valid[o];
        end
    end

    assign clash = |hit;

endmodule

>>> rtl/core/dram_fr_fcfs_scheduler.sv
// ----------------------------------------------------------------------------
// dram_fr_fcfs_scheduler
// FR-FCFS request scheduler for one DRAM channel of eight banks.
// ----------------------------------------------------------------------------
// usage
//   input beats: tuser is the opcode (0 add, 1 tick), tdata the request tag
//   output beats: one per input beat, see the port comments for the fields
//   config: cfg_we, cfg_addr, cfg_wdata write a timing register or the row mask
// operation
//   an add is written to the pending queue on accept, or dropped when the
//   queue is full, and its result goes on to the result register; a tick
//   first scans the ongoing requests to find the one to retire, then scans
//   the pending entries in order (memory read, window build, clash check),
//   ends the scan, issues, and, when an issued request is removed from the
//   pending queue, moves each later entry down one place, reading it and
//   then writing it back, before it finishes
// reset
//   queue empty, no ongoing request, all banks closed, cycle counter zero,
//   timing registers at their defaults; no clearing pass is needed
// stalls
//   the result register holds a beat until taken; a new beat is accepted
//   while it waits, and its result waits until the register frees up
// ----------------------------------------------------------------------------
module dram_fr_fcfs_scheduler #(
    parameter int PENDING_DEPTH = dfs_pkg::PENDING_DEPTH_DEF,
    parameter int ONGOING_DEPTH = dfs_pkg::ONGOING_DEPTH_DEF,
    parameter int TAG_BITS      = dfs_pkg::TAG_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input beat
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dfs_pkg::IN_DATA_W-1:0]    s_tdata,  // request_tag
    input  logic [0:0]                       s_tuser,  // opcode
    // output beat
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // completed_valid, completed_tag, issued_valid, issued_tag, queue_full,
    // pending_count
    output logic [dfs_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [1:0]                       m_tuser,  // issued_kind
    // configuration
    input  logic                             cfg_we,
    input  logic [dfs_pkg::CFG_AW-1:0]       cfg_addr,
    input  logic [dfs_pkg::CFG_W-1:0]        cfg_wdata
);
    import dfs_pkg::*;

    localparam int PEND_AW = $clog2(PENDING_DEPTH);
    localparam int CNT_W   = $clog2(PENDING_DEPTH + 1);
    localparam int ONG_AW  = (ONGOING_DEPTH > 1) ? $clog2(ONGOING_DEPTH) : 1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RETIRE = 8'b0000_0010,
        S_FETCH  = 8'b0000_0100,
        S_EVAL   = 8'b0000_1000,
        S_CHECK  = 8'b0001_0000,
        S_ISSUE  = 8'b0010_0000,
        S_SHRD   = 8'b0100_0000,
        S_SHWR   = 8'b1000_0000
    } state_t;

    // configuration registers
    logic [CMD_W-1:0]       cmd_bus_reg;
    logic [BANK_BUSY_W-1:0] bank_busy_reg;
    logic [DATA_BUS_W-1:0]  data_bus_reg;
    logic [CFG_W-1:0]       row_mask_reg;

    // control registers
    state_t               state_reg, state_next;
    logic                 resp_reg, resp_next;
    logic [CYCLE_W-1:0]   cycle_reg, cycle_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [ONG_AW-1:0]    r_reg, r_next;
    logic                 pick_v_reg, pick_v_next;
    logic [ONG_AW-1:0]    pick_idx_reg, pick_idx_next;
    logic [WIN_W-1:0]     pick_e_reg, pick_e_next;
    logic                 best_v_reg, best_v_next;
    logic [CNT_W-1:0]     best_idx_reg, best_idx_next;

    // result staging and output registers
    logic                 res_cv_reg, res_cv_next;
    logic [TAG_BITS-1:0]  res_ctag_reg, res_ctag_next;
    logic                 res_iv_reg, res_iv_next;
    logic [TAG_BITS-1:0]  res_itag_reg, res_itag_next;
    kind_t                res_kind_reg, res_kind_next;
    logic                 res_full_reg, res_full_next;
    logic                        m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]       m_data_reg, m_data_next;
    logic [1:0]                  m_user_reg, m_user_next;

    // candidate and best request
    win_t                 cand_reg, cand_next;
    logic [TAG_BITS-1:0]  cand_tag_reg;
    logic [BANK_W-1:0]    cand_bank_reg;
    kind_t                cand_kind_reg;
    win_t                 best_win_reg;
    logic [TAG_BITS-1:0]  best_tag_reg;
    kind_t                best_kind_reg;

    // ongoing table and bank rows
    logic [ONGOING_DEPTH-1:0]               ong_valid_reg;
    win_t [ONGOING_DEPTH-1:0]               ong_win_reg;
    logic [ONGOING_DEPTH-1:0][BANK_W-1:0]   ong_bank_reg;
    logic [ONGOING_DEPTH-1:0][TAG_BITS-1:0] ong_tag_reg;
    logic [7:0]                             bank_open_reg;
    logic [7:0][TAG_BITS-1:0]               bank_row_reg;

    // pending queue memory
    logic [TAG_BITS-1:0]  pend_mem [PENDING_DEPTH];
    logic [TAG_BITS-1:0]  rd_data_reg;
    logic [PEND_AW-1:0]   rd_addr;
    logic                 wr_en;
    logic [PEND_AW-1:0]   wr_addr;
    logic [TAG_BITS-1:0]  wr_data;

    // helper signals
    logic                 accept;
    logic [WIN_W-1:0]     now_w;
    logic [WIN_W-1:0]     c_eff, b_eff, d_eff;
    logic                 scan_hit;
    logic                 fin_v;
    logic [ONG_AW-1:0]    fin_idx;
    logic                 free_any;
    logic [ONG_AW-1:0]    free_idx;
    logic [BANK_W-1:0]    ev_bank;
    logic [TAG_BITS-1:0]  ev_row;
    kind_t                ev_kind;
    logic [WIN_W-1:0]     ev_s2;
    logic                 clash;
    logic                 retire_en;
    logic                 issue_en;
    logic [CNT_W+4:0]     used_ext;
    logic [BANK_W-1:0]    best_bank;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !resp_reg;
    assign now_w    = WIN_W'(cycle_reg);
    assign c_eff    = WIN_W'((cmd_bus_reg == '0) ? CMD_W'(1) : cmd_bus_reg);
    assign b_eff    = WIN_W'((bank_busy_reg == '0) ? BANK_BUSY_W'(1) : bank_busy_reg);
    assign d_eff    = WIN_W'((data_bus_reg == '0) ? DATA_BUS_W'(1) : data_bus_reg);
    assign best_bank = best_tag_reg[BANK_LSB +: BANK_W];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus_reg   <= CMD_BUS_RST;
            bank_busy_reg <= BANK_BUSY_RST;
            data_bus_reg  <= DATA_BUS_RST;
            row_mask_reg  <= ROW_MASK_RST;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_CMD_BUS:   cmd_bus_reg   <= cfg_wdata[CMD_W-1:0];
                REG_BANK_BUSY: bank_busy_reg <= cfg_wdata[BANK_BUSY_W-1:0];
                REG_DATA_BUS:  data_bus_reg  <= cfg_wdata[DATA_BUS_W-1:0];
                REG_ROW_MASK:  row_mask_reg  <= cfg_wdata;
                default:       row_mask_reg  <= row_mask_reg;
            endcase
        end
    end

    // retire search: one ongoing entry per cycle, earliest data end wins
    assign scan_hit = ong_valid_reg[r_reg] && (ong_win_reg[r_reg].data_e <= now_w) &&
                      (!pick_v_reg || (ong_win_reg[r_reg].data_e < pick_e_reg));
    assign fin_v    = scan_hit || pick_v_reg;
    assign fin_idx  = scan_hit ? r_reg : pick_idx_reg;

    // first free ongoing slot
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int o = ONGOING_DEPTH - 1; o >= 0; o--)
        begin
            if (!ong_valid_reg[o])
            begin
                free_any = 1'b1;
                free_idx = ONG_AW'(o);
            end
        end
    end

    // classify the fetched entry and build its windows
    always_comb
    begin
        ev_bank = rd_data_reg[BANK_LSB +: BANK_W];
        ev_row  = rd_data_reg & row_mask_reg[TAG_BITS-1:0];
        if (!bank_open_reg[ev_bank])
        begin
            ev_kind = KIND_MISS;
        end
        else if (bank_row_reg[ev_bank] == ev_row)
        begin
            ev_kind = KIND_HIT;
        end
        else
        begin
            ev_kind = KIND_CONFLICT;
        end
        case (ev_kind)
            KIND_HIT:  ev_s2 = now_w;
            KIND_MISS: ev_s2 = now_w + b_eff;
            default:   ev_s2 = now_w + (b_eff << 1);
        endcase
        cand_next.used    = {1'b1, ev_kind != KIND_HIT, ev_kind == KIND_CONFLICT};
        cand_next.cs[0]   = now_w;
        cand_next.cs[1]   = (ev_kind == KIND_CONFLICT) ? now_w + b_eff : now_w;
        cand_next.cs[2]   = ev_s2;
        cand_next.ce[0]   = cand_next.cs[0] + c_eff - WIN_W'(1);
        cand_next.ce[1]   = cand_next.cs[1] + c_eff - WIN_W'(1);
        cand_next.ce[2]   = ev_s2 + c_eff - WIN_W'(1);
        cand_next.bank_s  = now_w;
        cand_next.bank_e  = ev_s2 + b_eff - WIN_W'(1);
        cand_next.data_s  = ev_s2 + b_eff;
        cand_next.data_e  = ev_s2 + b_eff + d_eff - WIN_W'(1);
    end

    dfs_clash #(
        .ONGOING_DEPTH (ONGOING_DEPTH)
    ) u_clash (
        .cand      (cand_reg),
        .cand_bank (cand_bank_reg),
        .ong_valid (ong_valid_reg),
        .ong_win   (ong_win_reg),
        .ong_bank  (ong_bank_reg),
        .clash     (clash)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        resp_next      = resp_reg;
        cycle_next     = cycle_reg;
        used_next      = used_reg;
        k_next         = k_reg;
        r_next         = r_reg;
        pick_v_next    = pick_v_reg;
        pick_idx_next  = pick_idx_reg;
        pick_e_next    = pick_e_reg;
        best_v_next    = best_v_reg;
        best_idx_next  = best_idx_reg;
        res_cv_next    = res_cv_reg;
        res_ctag_next  = res_ctag_reg;
        res_iv_next    = res_iv_reg;
        res_itag_next  = res_itag_reg;
        res_kind_next  = res_kind_reg;
        res_full_next  = res_full_reg;
        rd_addr        = k_reg[PEND_AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = used_reg[PEND_AW-1:0];
        wr_data        = s_tdata[TAG_BITS-1:0];
        retire_en      = 1'b0;
        issue_en       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_cv_next   = 1'b0;
                    res_ctag_next = '0;
                    res_iv_next   = 1'b0;
                    res_itag_next = '0;
                    res_kind_next = KIND_HIT;
                    res_full_next = 1'b0;
                    if (opcode_t'(s_tuser[0]) == OP_ADD)
                    begin
                        if (used_reg >= CNT_W'(PENDING_DEPTH))
                        begin
                            res_full_next = 1'b1;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            used_next = used_reg + CNT_W'(1);
                        end
                        resp_next = 1'b1;
                    end
                    else
                    begin
                        r_next      = '0;
                        pick_v_next = 1'b0;
                        state_next  = S_RETIRE;
                    end
                end
            end
            S_RETIRE:
            begin
                if (scan_hit)
                begin
                    pick_v_next   = 1'b1;
                    pick_idx_next = r_reg;
                    pick_e_next   = ong_win_reg[r_reg].data_e;
                end
                if (r_reg == ONG_AW'(ONGOING_DEPTH - 1))
                begin
                    if (fin_v)
                    begin
                        retire_en     = 1'b1;
                        res_cv_next   = 1'b1;
                        res_ctag_next = ong_tag_reg[fin_idx];
                    end
                    k_next      = '0;
                    best_v_next = 1'b0;
                    state_next  = S_FETCH;
                end
                else
                begin
                    r_next = r_reg + ONG_AW'(1);
                end
            end
            S_FETCH:
            begin
                if ((k_reg < used_reg) && free_any)
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    state_next = S_ISSUE;
                end
            end
            S_EVAL:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!clash && ((cand_kind_reg == KIND_HIT) || !best_v_reg))
                begin
                    best_v_next   = 1'b1;
                    best_idx_next = k_reg;
                end
                k_next = k_reg + CNT_W'(1);
                if (!clash && (cand_kind_reg == KIND_HIT))
                begin
                    state_next = S_ISSUE;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_ISSUE:
            begin
                cycle_next = cycle_reg + CYCLE_W'(1);
                if (best_v_reg)
                begin
                    issue_en      = 1'b1;
                    res_iv_next   = 1'b1;
                    res_itag_next = best_tag_reg;
                    res_kind_next = best_kind_reg;
                    k_next        = best_idx_reg;
                    state_next    = S_SHRD;
                end
                else
                begin
                    resp_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SHRD:
            begin
                // close the gap left by the issued entry
                rd_addr = PEND_AW'(k_reg + CNT_W'(1));
                if ((k_reg + CNT_W'(1)) < used_reg)
                begin
                    state_next = S_SHWR;
                end
                else
                begin
                    used_next  = used_reg - CNT_W'(1);
                    resp_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SHWR:
            begin
                wr_en      = 1'b1;
                wr_addr    = k_reg[PEND_AW-1:0];
                wr_data    = rd_data_reg;
                k_next     = k_reg + CNT_W'(1);
                state_next = S_SHRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register, loaded when free or being taken
    assign used_ext = (CNT_W + 5)'(resp_reg ? used_reg : used_reg);
    always_comb
    begin
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (resp_reg && (!m_valid_reg || m_tready))
        begin
            m_valid_next = 1'b1;
            m_data_next  = {used_ext[COUNT_W-1:0], res_full_reg,
                            FIELD_TAG_W'(res_itag_reg), res_iv_reg,
                            FIELD_TAG_W'(res_ctag_reg), res_cv_reg};
            m_user_next  = res_kind_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            resp_reg     <= 1'b0;
            cycle_reg    <= '0;
            used_reg     <= '0;
            k_reg        <= '0;
            r_reg        <= '0;
            pick_v_reg   <= 1'b0;
            best_v_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            resp_reg     <= (resp_reg && m_valid_reg && !m_tready) ? 1'b1 :
                            (resp_reg ? 1'b0 : resp_next);
            cycle_reg    <= cycle_next;
            used_reg     <= used_next;
            k_reg        <= k_next;
            r_reg        <= r_next;
            pick_v_reg   <= pick_v_next;
            best_v_reg   <= best_v_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pick_idx_reg <= pick_idx_next;
        pick_e_reg   <= pick_e_next;
        best_idx_reg <= best_idx_next;
        res_cv_reg   <= res_cv_next;
        res_ctag_reg <= res_ctag_next;
        res_iv_reg   <= res_iv_next;
        res_itag_reg <= res_itag_next;
        res_kind_reg <= res_kind_next;
        res_full_reg <= res_full_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
        if (state_reg == S_EVAL)
        begin
            cand_reg      <= cand_next;
            cand_tag_reg  <= rd_data_reg;
            cand_bank_reg <= ev_bank;
            cand_kind_reg <= ev_kind;
        end
        if ((state_reg == S_CHECK) && !clash &&
            ((cand_kind_reg == KIND_HIT) || !best_v_reg))
        begin
            best_win_reg  <= cand_reg;
            best_tag_reg  <= cand_tag_reg;
            best_kind_reg <= cand_kind_reg;
        end
    end

    // ongoing table and bank rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ong_valid_reg <= '0;
            bank_open_reg <= '0;
            bank_row_reg  <= '0;
        end
        else
        begin
            if (retire_en)
            begin
                ong_valid_reg[fin_idx] <= 1'b0;
            end
            if (issue_en)
            begin
                ong_valid_reg[free_idx]  <= 1'b1;
                bank_open_reg[best_bank] <= 1'b1;
                bank_row_reg[best_bank]  <= best_tag_reg & row_mask_reg[TAG_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_en)
        begin
            ong_win_reg[free_idx]  <= best_win_reg;
            ong_bank_reg[free_idx] <= best_bank;
            ong_tag_reg[free_idx]  <= best_tag_reg;
        end
    end

    // pending queue memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pend_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= pend_mem[rd_addr];
    end

endmodule

>>> rtl/core/dfs_checker.sv
// ----------------------------------------------------------------------------
// dfs_checker
// Port-level checks of the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module dfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // no issue means zero tag and kind
    a_issue_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[33] |-> (m_tdata[65:34] == 32'd0) && (m_tuser == 2'd0))
        else $error("issued fields set without an issue");

    // no completion means zero tag
    a_cpl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[32:1] == 32'd0))
        else $error("completed tag set without a completion");

    // a dropped add reports neither completion nor issue
    a_full_add: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[66] |-> !m_tdata[0] && !m_tdata[33])
        else $error("queue full reported on a tick");

endmodule

bind dram_fr_fcfs_scheduler dfs_checker u_dfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FR-FCFS DRAM scheduler: adds and ticks are
// streamed in under random bursts and gaps, and every output beat is compared
// with a scheduler model kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
    import dfs_pkg::*;

    // windows of one scheduled request, in full 64-bit cycle terms
    typedef struct {
        bit              used [3];
        longint unsigned cs [3];
        longint unsigned ce [3];
        longint unsigned bs;
        longint unsigned be;
        longint unsigned ds;
        longint unsigned de;
    } sched_win_t;

    typedef struct {
        bit        done_valid;
        bit [31:0] done_tag;
        bit        issue_valid;
        bit [31:0] issue_tag;
        bit [1:0]  issue_kind;
        bit        dropped;
        bit [4:0]  waiting;
    } sched_result_t;

    // scheduler model and store of expected output beats
    class sched_scoreboard;
        bit [4:0]   cmd_len;
        bit [9:0]   busy_len;
        bit [7:0]   xfer_len;
        bit [31:0]  row_mask;
        bit [31:0]  cycle_no;
        bit [31:0]  queue_tag [16];
        int         queue_len;
        bit         busy_valid [8];
        bit [31:0]  busy_tag [8];
        bit [2:0]   busy_bank [8];
        sched_win_t busy_win [8];
        bit         row_open [8];
        bit [31:0]  open_row [8];
        sched_result_t expected_beats [$];
        int         errors;

        function new();
            cmd_len   = CMD_BUS_RST;
            busy_len  = BANK_BUSY_RST;
            xfer_len  = DATA_BUS_RST;
            row_mask  = ROW_MASK_RST;
            cycle_no  = 0;
            queue_len = 0;
            errors    = 0;
            foreach (busy_valid[i])
            begin
                busy_valid[i] = 0;
                row_open[i]   = 0;
                open_row[i]   = 0;
            end
        endfunction

        function void write_reg(reg_idx_t idx, bit [31:0] value);
            case (idx)
                REG_CMD_BUS:   cmd_len  = value[4:0];
                REG_BANK_BUSY: busy_len = value[9:0];
                REG_DATA_BUS:  xfer_len = value[7:0];
                REG_ROW_MASK:  row_mask = value;
                default: ;
            endcase
        endfunction

        function sched_win_t build_windows(kind_t kind, longint unsigned c);
            sched_win_t w;
            longint unsigned cl, bl, dl;
            cl = (cmd_len == 0) ? 1 : cmd_len;
            bl = (busy_len == 0) ? 1 : busy_len;
            dl = (xfer_len == 0) ? 1 : xfer_len;
            foreach (w.used[i])
            begin
                w.used[i] = 0;
                w.cs[i]   = 0;
                w.ce[i]   = 0;
            end
            w.bs = c;
            // precharge
            if (kind == KIND_CONFLICT)
            begin
                w.used[0] = 1; w.cs[0] = c; w.ce[0] = c + cl - 1;
                c += bl;
            end
            // activate
            if (kind != KIND_HIT)
            begin
                w.used[1] = 1; w.cs[1] = c; w.ce[1] = c + cl - 1;
                c += bl;
            end
            // read or write, then the transfer
            w.used[2] = 1; w.cs[2] = c; w.ce[2] = c + cl - 1;
            w.be = c + bl - 1;
            w.ds = c + bl;
            w.de = w.ds + dl - 1;
            return w;
        endfunction

        function bit windows_clash(sched_win_t o, bit [2:0] obank,
                                   sched_win_t r, bit [2:0] rbank);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    if (o.used[i] && r.used[j] && o.cs[i] <= r.ce[j] && r.cs[j] <= o.ce[i])
                        return 1;
            if (o.ds <= r.de && r.ds <= o.de)
                return 1;
            return obank == rbank && o.bs <= r.be && r.bs <= o.be;
        endfunction

        // work out the beat caused by an accepted input
        function void note_input(opcode_t op, bit [31:0] tag);
            sched_result_t res;
            longint unsigned now;
            int pick, slot, best;
            kind_t best_kind, kind;
            sched_win_t best_w, w;
            bit [2:0] bank;
            bit ok;
            res = '{default: 0};
            if (op == OP_ADD)
            begin
                if (queue_len >= 16)
                    res.dropped = 1;
                else
                    queue_tag[queue_len++] = tag;
            end
            else
            begin
                now = cycle_no;
                pick = -1; slot = -1; best = -1;
                best_kind = KIND_HIT;
                // retire the earliest finished transfer
                for (int k = 0; k < 8; k++)
                    if (busy_valid[k] && busy_win[k].de <= now &&
                        (pick < 0 || busy_win[k].de < busy_win[pick].de))
                        pick = k;
                if (pick >= 0)
                begin
                    busy_valid[pick] = 0;
                    res.done_valid = 1;
                    res.done_tag = busy_tag[pick];
                end
                for (int k = 0; k < 8; k++)
                    if (!busy_valid[k] && slot < 0)
                        slot = k;
                // oldest-first scan, first clean hit wins
                if (slot >= 0)
                begin
                    for (int k = 0; k < queue_len; k++)
                    begin
                        bank = queue_tag[k][7:5];
                        if (!row_open[bank])
                            kind = KIND_MISS;
                        else if (open_row[bank] == (queue_tag[k] & row_mask))
                            kind = KIND_HIT;
                        else
                            kind = KIND_CONFLICT;
                        w = build_windows(kind, now);
                        ok = 1;
                        for (int o = 0; o < 8; o++)
                            if (busy_valid[o] && windows_clash(busy_win[o], busy_bank[o], w, bank))
                                ok = 0;
                        if (ok && (kind == KIND_HIT || best < 0))
                        begin
                            best = k; best_kind = kind; best_w = w;
                            if (kind == KIND_HIT)
                                break;
                        end
                    end
                end
                if (best >= 0)
                begin
                    bank = queue_tag[best][7:5];
                    busy_valid[slot] = 1;
                    busy_tag[slot]   = queue_tag[best];
                    busy_bank[slot]  = bank;
                    busy_win[slot]   = best_w;
                    row_open[bank]   = 1;
                    open_row[bank]   = queue_tag[best] & row_mask;
                    res.issue_valid  = 1;
                    res.issue_tag    = queue_tag[best];
                    res.issue_kind   = best_kind;
                    for (int k = best; k + 1 < queue_len; k++)
                        queue_tag[k] = queue_tag[k + 1];
                    queue_len--;
                end
                cycle_no++;
            end
            res.waiting = queue_len[4:0];
            expected_beats.push_back(res);
        endfunction

        function void compare(string name, bit [31:0] exp_v, bit [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_beat(logic [OUT_DATA_W-1:0] data, logic [1:0] kind);
            sched_result_t e;
            if (expected_beats.size() == 0)
            begin
                $error("unexpected output beat %0h", data);
                errors++;
                return;
            end
            e = expected_beats.pop_front();
            compare("completed_valid", e.done_valid, data[0]);
            compare("completed_tag", e.done_tag, data[32:1]);
            compare("issued_valid", e.issue_valid, data[33]);
            compare("issued_tag", e.issue_tag, data[65:34]);
            compare("queue_full", e.dropped, data[66]);
            compare("pending_count", e.waiting, data[71:67]);
            compare("issued_kind", e.issue_kind, kind);
        endfunction
    endclass

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = 0;
    logic [0:0]            s_tuser = 0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_we = 0;
    logic [CFG_AW-1:0]     cfg_addr = 0;
    logic [CFG_W-1:0]      cfg_wdata = 0;

    sched_scoreboard sb = new();
    int burst_left = 0;
    int idle_cycles = 0;
    bit [23:0] row_pool [4];

    dram_fr_fcfs_scheduler dut (.*);

    always #10 clk = ~clk;

    // receiver stall pattern: quiet stretches and stretches of short stalls
    int stall_left = 0;
    int quiet_left = 0;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 0;
            stall_left--;
        end
        else
        begin
            m_tready <= 1;
            if (quiet_left > 0)
                quiet_left--;
            else if ($urandom_range(0, 99) < 5)
                quiet_left = $urandom_range(20, 200);
            else if ($urandom_range(0, 99) < 30)
                stall_left = $urandom_range(1, 8);
        end
    end

    // output check and watchdog
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_beat(m_tdata, m_tuser);
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > 20000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_beat(opcode_t op, bit [31:0] tag);
        // bursts of random length separated by random gaps
        if (burst_left == 0)
        begin
            s_tvalid = 0;
            repeat ($urandom_range(0, 10)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid = 1;
        s_tuser  = op;
        s_tdata  = tag;
        do @(posedge clk); while (!s_tready);
        sb.note_input(op, tag);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid = 0;
        burst_left = 0;
        while (sb.expected_beats.size() != 0) @(negedge clk);
        // a tick may still be compacting the queue
        repeat (150) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, bit [31:0] value);
        cfg_we    = 1;
        cfg_addr  = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 0;
        sb.write_reg(idx, value);
    endtask

    function automatic bit [31:0] pick_tag();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return {row_pool[$urandom_range(0, 3)], 3'($urandom_range(0, 7)),
                5'($urandom_range(0, 31))};
    endfunction

    task automatic run_phase(int count, bit [4:0] c, bit [9:0] b, bit [7:0] d, bit [31:0] m);
        drain();
        write_reg(REG_CMD_BUS, c);
        write_reg(REG_BANK_BUSY, b);
        write_reg(REG_DATA_BUS, d);
        write_reg(REG_ROW_MASK, m);
        foreach (row_pool[i])
            row_pool[i] = $urandom;
        for (int i = 0; i < count; i++)
            if ($urandom_range(0, 99) < 65)
                send_beat(OP_TICK, $urandom);
            else
                send_beat(OP_ADD, pick_tag());
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: tag extremes, queue overflow, then ticks
        send_beat(OP_ADD, 32'h0);
        send_beat(OP_ADD, 32'hFFFF_FFFF);
        send_beat(OP_TICK, 32'hFFFF_FFFF);
        for (int i = 0; i < 16; i++)
            send_beat(OP_ADD, {24'h0, 3'(i), 5'(i)});
        for (int i = 0; i < 5; i++)
            send_beat(OP_TICK, 32'h0);

        // random phases across timing settings, zero and maximum included
        run_phase(400, 4, 100, 50, 32'hFFFF_FF00);
        run_phase(400, 0, 0, 0, 32'h0);
        run_phase(400, 31, 1023, 255, 32'hFFFF_FFFF);
        run_phase(400, 1, 1, 1, 32'hFFFF_FF00);
        run_phase(400, 5'($urandom_range(1, 16)), 10'($urandom_range(1, 60)),
                  8'($urandom_range(1, 40)), 32'hFFFF_0000);

        drain();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
